[hw/rtl/qxmm_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the motor mixer.
`default_nettype none

package qxmm_pkg;

  // Q format: 1.0 = 2^FRAC_BITS
  localparam int FRAC_BITS = 14;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int HALF_Q    = ONE_Q / 2;
  localparam int FLOOR_RST = ONE_Q / 10;

  // field and register widths
  localparam int IN_W       = 16;
  localparam int DRV_W      = 17;
  localparam int MIX_W      = 18;
  localparam int FLOOR_W    = 14;
  localparam int CEIL_W     = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // scaling divider: |m| * ceiling / max, quotient below 2^QUO_W
  localparam int DIVR_W    = 17;
  localparam int QUO_W     = 16;
  localparam int PROD_W    = DIVR_W + CEIL_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL  = 2'd1;

  typedef enum logic [1:0] {
    CMD_MIX    = 2'd0,
    CMD_ARM    = 2'd1,
    CMD_DISARM = 2'd2,
    CMD_CAL    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    STS_APPLIED = 2'd0,
    STS_IGNORED = 2'd1,
    STS_REFUSED = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic clamp;
    logic mix;
    logic find_max;
    logic mul;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mix_go;
    logic need_scale;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/qxmm_ctrl.sv]
// Sequencer for the motor mixer: item handshake, step order, divider count, result beat.
`default_nettype none

module qxmm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qxmm_pkg::dp_cmd_t       dp_cmd,
  input  wire qxmm_pkg::dp_stat_t dp_stat
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_MIX,
    S_MAX,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [qxmm_pkg::CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         accept;
  logic                         commit;

  localparam logic [qxmm_pkg::CNT_W-1:0] CNT_LAST = qxmm_pkg::CNT_W'(qxmm_pkg::DIV_STEPS - 1);

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign commit    = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    dp_cmd      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = S_CLAMP;
        end
      end
      S_CLAMP: begin
        dp_cmd.clamp = 1'b1;
        state_nxt    = dp_stat.mix_go ? S_MIX : S_COMMIT;
      end
      S_MIX: begin
        dp_cmd.mix = 1'b1;
        state_nxt  = S_MAX;
      end
      S_MAX: begin
        dp_cmd.find_max = 1'b1;
        state_nxt       = dp_stat.need_scale ? S_MUL : S_COMMIT;
      end
      S_MUL: begin
        dp_cmd.mul  = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        dp_cmd.div_step = 1'b1;
        div_cnt_nxt     = div_cnt_r + 1'b1;
        if (div_cnt_r == CNT_LAST) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        dp_cmd.commit = commit;
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted item always starts at the clamp step
  a_accept_to_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CLAMP))
    else $error("accepted item did not enter clamp step");

  // divider run always starts from a cleared count
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> (state_r == S_DIV && div_cnt_r == '0))
    else $error("divider run started with stale count");

  // a new result beat only appears after a commit
  a_beat_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(commit))
    else $error("result beat raised without commit");

endmodule

`default_nettype wire

[hw/rtl/qxmm_dpath.sv]
// Mixer datapath: config regs, clamp, X mix, max, four divider lanes, arming flags, result regs.
`default_nettype none

module qxmm_dpath (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire qxmm_pkg::dp_cmd_t                       dp_cmd,
  output qxmm_pkg::dp_stat_t                           dp_stat,
  input  wire logic                                    cfg_we,
  input  wire logic        [qxmm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [qxmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic        [1:0]                       in_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]        in_collective_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]        in_roll_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]        in_pitch_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]        in_yaw_cmd,
  output logic signed      [qxmm_pkg::DRV_W-1:0]       out_front_right_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]       out_front_left_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]       out_back_left_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]       out_back_right_drive,
  output logic                                         out_engaged_out,
  output logic                                         out_ready_out,
  output logic             [1:0]                       out_status
);

  localparam int IW  = qxmm_pkg::IN_W;
  localparam int DW  = qxmm_pkg::DRV_W;
  localparam int MW  = qxmm_pkg::MIX_W;
  localparam int FW  = qxmm_pkg::FLOOR_W;
  localparam int CW  = qxmm_pkg::CEIL_W;
  localparam int RW  = qxmm_pkg::DIVR_W;
  localparam int QW  = qxmm_pkg::QUO_W;
  localparam int PW  = qxmm_pkg::PROD_W;
  localparam int DVW = RW + QW;

  localparam logic [qxmm_pkg::CFG_DATA_W-1:0] CFG_HALF = qxmm_pkg::CFG_DATA_W'(qxmm_pkg::HALF_Q);
  localparam logic [qxmm_pkg::CFG_DATA_W-1:0] CFG_ONE  = qxmm_pkg::CFG_DATA_W'(qxmm_pkg::ONE_Q);
  localparam logic signed [IW-1:0] UNIT_POS = IW'(qxmm_pkg::ONE_Q);
  localparam logic signed [IW-1:0] UNIT_NEG = -IW'(qxmm_pkg::ONE_Q);

  // config and arming state
  logic [FW-1:0]          floor_r;
  logic [CW-1:0]          ceil_r;
  logic                   engaged_r, engaged_nxt;
  logic                   esc_ready_r, esc_ready_nxt;
  logic signed [DW-1:0]   drive_r   [4];
  logic signed [DW-1:0]   drive_nxt [4];
  qxmm_pkg::status_t      status_nxt;

  // latched item
  qxmm_pkg::cmd_code_t    cmd_r;
  logic signed [IW-1:0]   coll_r, roll_r, pitch_r, yaw_r;

  // mix pipeline
  logic [CW-1:0]          c_r, c_nxt;
  logic signed [IW-1:0]   r_r, p_r, y_r;
  logic signed [MW-1:0]   m_r   [4];
  logic signed [MW-1:0]   m_nxt [4];
  logic signed [MW-1:0]   mx01, mx23, mx;
  logic [RW-1:0]          mx_r;
  logic                   scale_r;

  // divider lanes: {remainder, dividend low / quotient}
  logic [DVW-1:0]         div_r [4];
  logic                   neg_r [4];
  logic [RW-1:0]          mag   [4];
  logic [PW-1:0]          prod  [4];
  logic [RW:0]            trial [4];
  logic [DVW-1:0]         div_nxt [4];
  logic signed [DW-1:0]   scaled [4];
  logic                   rem_ok;

  logic signed [DW-1:0]   coll_x, floor_x, ceil_x;

  function automatic logic signed [IW-1:0] clamp_unit(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] res;
    res = v;
    if (v < UNIT_NEG) begin
      res = UNIT_NEG;
    end else if (v > UNIT_POS) begin
      res = UNIT_POS;
    end
    return res;
  endfunction

  // collective clamp to [floor, ceiling]
  assign coll_x  = {coll_r[IW-1], coll_r};
  assign floor_x = $signed({{(DW-FW){1'b0}}, floor_r});
  assign ceil_x  = $signed({{(DW-CW){1'b0}}, ceil_r});

  always_comb begin
    if (coll_x < floor_x) begin
      c_nxt = {{(CW-FW){1'b0}}, floor_r};
    end else if (coll_x > ceil_x) begin
      c_nxt = ceil_r;
    end else begin
      c_nxt = coll_r[CW-1:0];
    end
  end

  // X-frame mix
  always_comb begin
    logic signed [MW-1:0] c18, r18, p18, y18;
    c18 = $signed({{(MW-CW){1'b0}}, c_r});
    r18 = MW'(r_r);
    p18 = MW'(p_r);
    y18 = MW'(y_r);
    m_nxt[0] = c18 + r18 - p18 - y18;
    m_nxt[1] = c18 - r18 - p18 + y18;
    m_nxt[2] = c18 - r18 + p18 - y18;
    m_nxt[3] = c18 + r18 + p18 + y18;
  end

  assign mx01 = (m_r[1] > m_r[0]) ? m_r[1] : m_r[0];
  assign mx23 = (m_r[3] > m_r[2]) ? m_r[3] : m_r[2];
  assign mx   = (mx23 > mx01) ? mx23 : mx01;

  assign dp_stat.need_scale = mx > $signed({{(MW-CW){1'b0}}, ceil_r});
  assign dp_stat.mix_go     = (cmd_r == qxmm_pkg::CMD_MIX) && engaged_r && esc_ready_r;

  // lane logic: magnitude product and one restoring division step
  always_comb begin
    rem_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      logic signed [MW-1:0] absm;
      absm       = (m_r[i] < 0) ? -m_r[i] : m_r[i];
      mag[i]     = absm[RW-1:0];
      prod[i]    = PW'(mag[i]) * PW'(ceil_r);
      trial[i]   = div_r[i][DVW-1:QW-1];
      if (trial[i] >= {1'b0, mx_r}) begin
        div_nxt[i] = {RW'(trial[i] - {1'b0, mx_r}), div_r[i][QW-2:0], 1'b1};
      end else begin
        div_nxt[i] = {trial[i][RW-1:0], div_r[i][QW-2:0], 1'b0};
      end
      scaled[i]  = neg_r[i] ? -$signed({1'b0, div_r[i][QW-1:0]})
                            :  $signed({1'b0, div_r[i][QW-1:0]});
      if (div_r[i][DVW-1:QW] >= mx_r) begin
        rem_ok = 1'b0;
      end
    end
  end

  // result of the command against the current arming state
  always_comb begin
    engaged_nxt   = engaged_r;
    esc_ready_nxt = esc_ready_r;
    status_nxt    = qxmm_pkg::STS_APPLIED;
    for (int i = 0; i < 4; i++) begin
      drive_nxt[i] = drive_r[i];
    end
    case (cmd_r)
      qxmm_pkg::CMD_MIX: begin
        if (dp_stat.mix_go) begin
          for (int i = 0; i < 4; i++) begin
            drive_nxt[i] = scale_r ? scaled[i] : m_r[i][DW-1:0];
          end
        end else begin
          status_nxt = qxmm_pkg::STS_IGNORED;
        end
      end
      qxmm_pkg::CMD_ARM: begin
        if (!engaged_r) begin
          if (esc_ready_r) begin
            engaged_nxt = 1'b1;
          end else begin
            status_nxt = qxmm_pkg::STS_REFUSED;
          end
        end
      end
      qxmm_pkg::CMD_DISARM: begin
        engaged_nxt = 1'b0;
        for (int i = 0; i < 4; i++) begin
          drive_nxt[i] = '0;
        end
      end
      qxmm_pkg::CMD_CAL: begin
        if (engaged_r) begin
          status_nxt = qxmm_pkg::STS_REFUSED;
        end else begin
          esc_ready_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // control state: config, arming flags, stored motors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r     <= FW'(qxmm_pkg::FLOOR_RST);
      ceil_r      <= CW'(qxmm_pkg::ONE_Q);
      engaged_r   <= 1'b0;
      esc_ready_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        drive_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          qxmm_pkg::REG_FLOOR: begin
            floor_r <= (cfg_data > CFG_HALF) ? CFG_HALF[FW-1:0] : cfg_data[FW-1:0];
          end
          qxmm_pkg::REG_CEIL: begin
            if (cfg_data < CFG_HALF) begin
              ceil_r <= CFG_HALF[CW-1:0];
            end else if (cfg_data > CFG_ONE) begin
              ceil_r <= CFG_ONE[CW-1:0];
            end else begin
              ceil_r <= cfg_data[CW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      if (dp_cmd.commit) begin
        engaged_r   <= engaged_nxt;
        esc_ready_r <= esc_ready_nxt;
        for (int i = 0; i < 4; i++) begin
          drive_r[i] <= drive_nxt[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      cmd_r   <= qxmm_pkg::cmd_code_t'(in_cmd);
      coll_r  <= in_collective_cmd;
      roll_r  <= in_roll_cmd;
      pitch_r <= in_pitch_cmd;
      yaw_r   <= in_yaw_cmd;
    end
    if (dp_cmd.clamp) begin
      c_r <= c_nxt;
      r_r <= clamp_unit(roll_r);
      p_r <= clamp_unit(pitch_r);
      y_r <= clamp_unit(yaw_r);
    end
    if (dp_cmd.mix) begin
      for (int i = 0; i < 4; i++) begin
        m_r[i] <= m_nxt[i];
      end
    end
    if (dp_cmd.find_max) begin
      mx_r    <= mx[RW-1:0];
      scale_r <= dp_stat.need_scale;
    end
    for (int i = 0; i < 4; i++) begin
      if (dp_cmd.mul) begin
        neg_r[i] <= m_r[i] < 0;
        div_r[i] <= {1'b0, prod[i]};
      end else if (dp_cmd.div_step) begin
        div_r[i] <= div_nxt[i];
      end
    end
    if (dp_cmd.commit) begin
      out_front_right_drive <= drive_nxt[0];
      out_front_left_drive  <= drive_nxt[1];
      out_back_left_drive   <= drive_nxt[2];
      out_back_right_drive  <= drive_nxt[3];
      out_engaged_out       <= engaged_nxt;
      out_ready_out         <= esc_ready_nxt;
      out_status            <= status_nxt;
    end
  end

  // partial remainder stays below the divisor on every step
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.div_step |-> rem_ok)
    else $error("divider remainder reached divisor");

  // scaling only ever flagged for a max above the ceiling
  a_scale_flag: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.find_max |=> (!scale_r || ({1'b0, mx_r} > {{(RW+1-CW){1'b0}}, ceil_r})))
    else $error("scale flagged with max not above ceiling");

endmodule

`default_nettype wire

[hw/rtl/quad_x_motor_mixer_with_arming.sv]
// Top level of the quad X-frame motor mixer with arming and calibration interlocks.
//
// Use: one command beat in on in_* (mix, arm, disarm/stop, calibration done), one
// result beat out on out_* per command, carrying all four stored motor values,
// the armed and calibrated flags and a status code. Both channels move a beat at
// a rising edge with valid high and stall low. Values are signed Q14 (1.0 = 16384).
// The cfg_* port writes floor (index 0) and ceiling (index 1); it is always ready,
// saturates the data to each register's range and ignores other indexes. The user
// writes it only while no command is in flight; the block does not enforce this.
// Timing: in_stall rises the cycle after a beat is accepted and falls after the
// result is committed to the output register. Arm, disarm, calibration or an
// ignored mix go from clamp straight to commit; an applied mix adds the mix and
// max steps; desaturation adds the multiply and the 16-step restoring divider
// (four lanes side by side). The result beat shows in the cycle after commit. A
// stalled result holds in the output register while the next command is already
// accepted; the commit of that next command waits until the held beat is taken.
// Reset (rst_n low, synchronous): disarmed, not calibrated, motors zero,
// floor 1638, ceiling 16384, no result pending.
`default_nettype none

module quad_x_motor_mixer_with_arming (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // command channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic        [1:0]                      in_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]       in_collective_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]       in_roll_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]       in_pitch_cmd,
  input  wire logic signed [qxmm_pkg::IN_W-1:0]       in_yaw_cmd,
  // result channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [qxmm_pkg::DRV_W-1:0]      out_front_right_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]      out_front_left_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]      out_back_left_drive,
  output logic signed      [qxmm_pkg::DRV_W-1:0]      out_back_right_drive,
  output logic                                        out_engaged_out,
  output logic                                        out_ready_out,
  output logic             [1:0]                      out_status,
  // register write port
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [qxmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [qxmm_pkg::CFG_DATA_W-1:0] cfg_data
);

  qxmm_pkg::dp_cmd_t  dp_cmd;
  qxmm_pkg::dp_stat_t dp_stat;
  logic               cfg_we;

  // register writes are always accepted
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: handshakes, step order, divider count
  qxmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  // datapath: clamp, mix, max, desaturation divide, flags and result registers
  qxmm_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .dp_cmd                (dp_cmd),
    .dp_stat               (dp_stat),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_cmd                (in_cmd),
    .in_collective_cmd     (in_collective_cmd),
    .in_roll_cmd           (in_roll_cmd),
    .in_pitch_cmd          (in_pitch_cmd),
    .in_yaw_cmd            (in_yaw_cmd),
    .out_front_right_drive (out_front_right_drive),
    .out_front_left_drive  (out_front_left_drive),
    .out_back_left_drive   (out_back_left_drive),
    .out_back_right_drive  (out_back_right_drive),
    .out_engaged_out       (out_engaged_out),
    .out_ready_out         (out_ready_out),
    .out_status            (out_status)
  );

endmodule

`default_nettype wire
